/* rtl/core/nst_pkg.sv */
package nst_pkg;

  localparam logic [1:0] CMD_HELLO     = 2'd0;
  localparam logic [1:0] CMD_HEARTBEAT = 2'd1;
  localparam logic [1:0] CMD_REPORT    = 2'd2;

  localparam logic [1:0] ST_UPDATED   = 2'd0;
  localparam logic [1:0] ST_SATURATED = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_ZERO_ADDR = 2'd3;

  localparam logic [15:0] COUNT_MAX  = 16'hffff;
  localparam logic [6:0]  HOPS_RESET = 7'd127;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [63:0] node_name;
    logic [6:0]  hop_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  slot_index;
    logic [7:0]  node_count;
    logic [1:0]  rank;
    logic [15:0] entry_address;
    logic [63:0] entry_name;
    logic [15:0] entry_hello_count;
    logic        entry_valid;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] address;
    logic [63:0] name;
    logic [6:0]  hop_lo;
    logic [6:0]  hop_hi;
    logic [15:0] hellos;
    logic [15:0] beats;
  } row_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic write;
    logic rank_read;
    logic rank_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
    logic top_empty;
    logic emit_last;
  } dp_stat_t;

  // bytes from the first zero byte on are cleared
  function automatic logic [63:0] clip_name(input logic [63:0] n);
    logic [63:0] r;
    logic        stop;
    r = '0;
    stop = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (n[8*b +: 8] == 8'd0) stop = 1'b1;
      if (!stop) r[8*b +: 8] = n[8*b +: 8];
    end
    return r;
  endfunction

endpackage

/* rtl/core/nst_ram.sv */
module nst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

/* rtl/core/nst_ctrl.sv */
module nst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  nst_pkg::in_item_t req,
  output logic              req_stall,
  input  nst_pkg::dp_stat_t st,
  output nst_pkg::ctrl_cmd_t cmd
);
  import nst_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_RREAD = 3'd3;
  localparam logic [2:0] S_REMIT = 3'd4;

  logic [2:0] state, state_next;
  logic       report, report_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    report_next = report;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        cmd.load = req_valid;
        if (req_valid) begin
          case (req.command)
            CMD_HELLO, CMD_HEARTBEAT: begin
              report_next = 1'b0;
              state_next  = (req.address == 16'd0) ? S_WRITE : S_SCAN;
            end
            CMD_REPORT: begin
              report_next = 1'b1;
              state_next  = S_SCAN;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) state_next = report ? S_RREAD : S_WRITE;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        if (st.out_free) state_next = S_IDLE;
      end
      S_RREAD: begin
        cmd.rank_read = !st.top_empty;
        state_next    = S_REMIT;
      end
      S_REMIT: begin
        cmd.rank_emit = 1'b1;
        if (st.out_free) state_next = st.emit_last ? S_IDLE : S_RREAD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      report <= 1'b0;
    end else begin
      state  <= state_next;
      report <= report_next;
    end
  end

endmodule

/* rtl/core/nst_dp.sv */
module nst_dp #(
  parameter int TABLE_ENTRIES = 128,
  parameter int TOP_COUNT     = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  nst_pkg::in_item_t   req,
  input  nst_pkg::ctrl_cmd_t  cmd,
  output nst_pkg::dp_stat_t   st,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output nst_pkg::out_item_t  rsp
);
  import nst_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int TW    = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam int NW    = $clog2(TOP_COUNT + 1);
  localparam int ROW_W = $bits(row_t);

  in_item_t         cur;
  logic [CNT_W-1:0] used, used_next, scan_idx;
  logic             chk_vld;
  logic [IDX_W-1:0] chk_idx;
  logic             found;
  logic [IDX_W-1:0] found_idx;
  row_t             hit_row;
  logic [IDX_W-1:0] top_idx [TOP_COUNT];
  logic [15:0]      top_cnt [TOP_COUNT];
  logic [NW-1:0]    top_n;
  logic [TW-1:0]    emit_j;
  out_item_t        rsp_q;
  logic             rsp_vld;

  logic [ROW_W-1:0] rd_data;
  row_t             rd_row;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic             is_report, issue_ok, hit_now, issuing, rank_ins;
  logic             ins_hit;
  logic [TW-1:0]    ins_pos;
  row_t             new_row;
  logic [1:0]       res_status;
  logic [IDX_W-1:0] res_idx;
  logic             wr_ok, step_w, step_r, out_free, emit_last;

  assign rd_row    = row_t'(rd_data);
  assign is_report = (cur.command == CMD_REPORT);
  assign issue_ok  = (scan_idx < used);
  assign hit_now   = cmd.scan && !is_report && chk_vld && (rd_row.address == cur.address);
  assign issuing   = cmd.scan && issue_ok && (is_report || (!found && !hit_now));
  assign rank_ins  = cmd.scan && is_report && chk_vld && (rd_row.hellos != 16'd0);
  assign rd_en     = issuing || cmd.rank_read;
  assign rd_addr   = cmd.rank_read ? top_idx[emit_j] : scan_idx[IDX_W-1:0];

  assign out_free  = !rsp_vld || !rsp_stall;
  assign emit_last = (top_n == '0) || ((NW'(emit_j) + NW'(1)) == top_n);
  assign step_w    = cmd.write && out_free;
  assign step_r    = cmd.rank_emit && out_free;

  assign st.scan_done = cmd.scan && (hit_now || (!issue_ok && !chk_vld));
  assign st.out_free  = out_free;
  assign st.top_empty = (top_n == '0);
  assign st.emit_last = emit_last;

  assign rsp_valid = rsp_vld;
  assign rsp       = rsp_q;

  nst_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (step_w && wr_ok),
    .waddr (res_idx),
    .wdata (ROW_W'(new_row)),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // first rank position the new count takes
  always_comb begin
    ins_hit = 1'b0;
    ins_pos = '0;
    for (int j = 0; j < TOP_COUNT; j++) begin
      if (!ins_hit && ((NW'(j) == top_n) ||
          ((NW'(j) < top_n) && (rd_row.hellos > top_cnt[j])))) begin
        ins_hit = 1'b1;
        ins_pos = TW'(j);
      end
    end
  end

  always_comb begin
    new_row    = hit_row;
    res_status = ST_UPDATED;
    res_idx    = found_idx;
    used_next  = used;
    wr_ok      = 1'b0;
    if (cur.address == 16'd0) begin
      res_status = ST_ZERO_ADDR;
      res_idx    = '0;
    end else if (found) begin
      wr_ok = 1'b1;
      if (cur.command == CMD_HELLO) begin
        new_row.name = clip_name(cur.node_name);
        if (hit_row.hellos < COUNT_MAX) new_row.hellos = hit_row.hellos + 16'd1;
        else res_status = ST_SATURATED;
      end else begin
        if (cur.hop_count < hit_row.hop_lo) new_row.hop_lo = cur.hop_count;
        else if (cur.hop_count > hit_row.hop_hi) new_row.hop_hi = cur.hop_count;
        if (hit_row.beats < COUNT_MAX) begin
          new_row.beats = hit_row.beats + 16'd1;
        end else begin
          res_status = ST_SATURATED;
        end
      end
    end else if (used < CNT_W'(TABLE_ENTRIES)) begin
      wr_ok     = 1'b1;
      res_idx   = used[IDX_W-1:0];
      used_next = used + CNT_W'(1);
      new_row.address = cur.address;
      if (cur.command == CMD_HELLO) begin
        new_row.name   = clip_name(cur.node_name);
        new_row.hop_lo = HOPS_RESET;
        new_row.hop_hi = 7'd0;
        new_row.hellos = 16'd1;
        new_row.beats  = 16'd0;
      end else begin
        new_row.name   = 64'd0;
        new_row.hop_lo = cur.hop_count;
        new_row.hop_hi = cur.hop_count;
        new_row.hellos = 16'd0;
        new_row.beats  = 16'd1;
      end
    end else begin
      res_status = ST_FULL;
      res_idx    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      chk_vld <= 1'b0;
      found   <= 1'b0;
      top_n   <= '0;
      emit_j  <= '0;
      rsp_vld <= 1'b0;
    end else begin
      chk_vld <= issuing;
      if (cmd.load) begin
        found  <= 1'b0;
        top_n  <= '0;
        emit_j <= '0;
      end else begin
        if (hit_now) found <= 1'b1;
        if (rank_ins && ins_hit && (top_n != NW'(TOP_COUNT))) top_n <= top_n + NW'(1);
        if (step_r) emit_j <= emit_j + TW'(1);
      end
      if (step_w) used <= used_next;
      if (step_w || step_r) rsp_vld <= 1'b1;
      else if (!rsp_stall) rsp_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur      <= req;
      scan_idx <= '0;
    end else if (issuing) begin
      scan_idx <= scan_idx + CNT_W'(1);
    end
    chk_idx <= scan_idx[IDX_W-1:0];
    if (hit_now) begin
      hit_row   <= rd_row;
      found_idx <= chk_idx;
    end
    if (rank_ins && ins_hit) begin
      for (int k = 1; k < TOP_COUNT; k++) begin
        if (TW'(k) > ins_pos) begin
          top_idx[k] <= top_idx[k-1];
          top_cnt[k] <= top_cnt[k-1];
        end
      end
      for (int k = 0; k < TOP_COUNT; k++) begin
        if (TW'(k) == ins_pos) begin
          top_idx[k] <= chk_idx;
          top_cnt[k] <= rd_row.hellos;
        end
      end
    end
    if (step_w) begin
      rsp_q                   <= '0;
      rsp_q.status            <= res_status;
      rsp_q.slot_index        <= 7'(res_idx);
      rsp_q.node_count        <= 8'(used_next);
      rsp_q.last              <= 1'b1;
    end else if (step_r) begin
      rsp_q            <= '0;
      rsp_q.node_count <= 8'(used);
      rsp_q.last       <= emit_last;
      if (top_n != '0) begin
        rsp_q.status            <= ST_UPDATED;
        rsp_q.slot_index        <= 7'(top_idx[emit_j]);
        rsp_q.rank              <= 2'(emit_j);
        rsp_q.entry_address     <= rd_row.address;
        rsp_q.entry_name        <= rd_row.name;
        rsp_q.entry_hello_count <= rd_row.hellos;
        rsp_q.entry_valid       <= 1'b1;
      end
    end
  end

endmodule

/* rtl/core/node_statistics_table.sv */
// Node statistics table: per-node hello/heartbeat counters keyed by address.
// Request channel req_valid/req_stall/req carries one item: command, address,
// node_name, hop_count. Response channel rsp_valid/rsp_stall/rsp returns the
// results; the final result of an item has last set.
// One item is worked at a time; req_stall is high from acceptance until the
// last result has been loaded into the response register.
// Hello/heartbeat: the table row memory is scanned one row per cycle over the
// occupied slots, stopping at a matching address, then the row is written
// back. A zero address skips the scan. Report: same scan, then each ranked
// row is read back through the single memory read port before its result
// is emitted.
// Command value three is accepted and dropped without a result.
// Reset empties the table at once: the occupied count is the fill mark, and
// rows beyond it are rewritten in full when claimed. No clearing pass.
// A stalled response holds its item; the block waits with the next result
// until the response register is free.
module node_statistics_table #(
  parameter int TABLE_ENTRIES = 128,
  parameter int TOP_COUNT     = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  nst_pkg::in_item_t  req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output nst_pkg::out_item_t rsp
);
  import nst_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  st;

  nst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  nst_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .TOP_COUNT(TOP_COUNT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  a_rank_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.entry_valid |-> rsp.status == ST_UPDATED)
    else $error("ranked result with bad status");

  a_plain_rank: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.entry_valid |-> rsp.rank == 2'd0 && rsp.last)
    else $error("unranked result not final");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.command == CMD_REPORT |=> req_stall)
    else $error("report accepted without going busy");

  a_reset_out: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid)
    else $error("result after reset");

endmodule

/* verif/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nst_pkg::*;

  localparam int SLOTS = 128;
  localparam int TOPN = 4;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  in_item_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  out_item_t rsp;

  node_statistics_table dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // table copy
  logic [15:0] t_addr [SLOTS];
  logic [63:0] t_name [SLOTS];
  logic [6:0]  t_min [SLOTS];
  logic [6:0]  t_max [SLOTS];
  logic [15:0] t_hello [SLOTS];
  logic [15:0] t_beat [SLOTS];
  int          occupied;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int        errors = 0;
  int        cycles = 0;
  bit        quiet = 1'b0;
  bit        hold_rsp = 1'b0;
  bit        stim_done = 1'b0;

  function automatic logic [63:0] keep_name(logic [63:0] n);
    logic [63:0] r;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      if (n[8*b +: 8] == 8'd0) break;
      r[8*b +: 8] = n[8*b +: 8];
    end
    return r;
  endfunction

  function automatic out_item_t plain_result(logic [1:0] st, int s);
    out_item_t o;
    o = '0;
    o.status = st;
    o.slot_index = s[6:0];
    o.node_count = occupied[7:0];
    o.last = 1'b1;
    return o;
  endfunction

  task automatic update_table(in_item_t it);
    int s;
    bit fresh;
    logic [1:0] st;
    int top [TOPN];
    int n;
    int m;
    out_item_t o;
    st = ST_UPDATED;
    fresh = 0;
    n = 0;
    if (it.command == CMD_HELLO || it.command == CMD_HEARTBEAT) begin
      if (it.address == 16'd0) begin
        expected_results.push_back(plain_result(ST_ZERO_ADDR, 0));
        return;
      end
      s = SLOTS;
      for (int i = 0; i < SLOTS; i++) begin
        if (t_addr[i] == 16'd0) begin
          fresh = 1; s = i; break;
        end
        if (t_addr[i] == it.address) begin
          s = i; break;
        end
      end
      if (s == SLOTS) begin
        expected_results.push_back(plain_result(ST_FULL, 0));
        return;
      end
      if (fresh) begin
        t_addr[s] = it.address;
        occupied++;
        if (it.command == CMD_HELLO) begin
          t_name[s] = keep_name(it.node_name);
          t_hello[s] = 16'd1;
        end else begin
          t_beat[s] = 16'd1;
          t_min[s] = it.hop_count;
          t_max[s] = it.hop_count;
        end
      end else if (it.command == CMD_HELLO) begin
        t_name[s] = keep_name(it.node_name);
        if (t_hello[s] != COUNT_MAX) t_hello[s]++;
        else st = ST_SATURATED;
      end else begin
        if (it.hop_count < t_min[s]) t_min[s] = it.hop_count;
        else if (it.hop_count > t_max[s]) t_max[s] = it.hop_count;
        if (t_beat[s] != COUNT_MAX) t_beat[s]++;
        else st = ST_SATURATED;
      end
      expected_results.push_back(plain_result(st, s));
    end else if (it.command == CMD_REPORT) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (t_addr[i] == 16'd0) break;
        if (t_hello[i] == 16'd0) continue;
        for (int j = 0; j < TOPN; j++) begin
          if (j == n) begin
            top[j] = i; n++; break;
          end
          if (t_hello[i] > t_hello[top[j]]) begin
            m = (n < TOPN) ? n : TOPN - 1;
            while (m > j) begin
              top[m] = top[m-1]; m--;
            end
            top[j] = i;
            if (n < TOPN) n++;
            break;
          end
        end
      end
      if (n == 0) begin
        expected_results.push_back(plain_result(ST_UPDATED, 0));
      end else begin
        for (int j = 0; j < n; j++) begin
          o = plain_result(ST_UPDATED, top[j]);
          o.rank = j[1:0];
          o.entry_address = t_addr[top[j]];
          o.entry_name = t_name[top[j]];
          o.entry_hello_count = t_hello[top[j]];
          o.entry_valid = 1'b1;
          o.last = (j + 1 == n);
          expected_results.push_back(o);
        end
      end
    end
  endtask

  task automatic report(string what, out_item_t got, out_item_t want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!(req_valid && req_stall)) begin
      if (req_valid) begin
        update_table(req);
        void'(pending_items.pop_front());
      end
      if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 7)) begin
        req_valid <= 1'b1;
        req <= pending_items[0];
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("node_statistics_table test failed");
      $finish;
    end
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          report("unexpected", rsp, '0);
        end else begin
          want = expected_results.pop_front();
          if (rsp.status !== want.status) report("status", rsp, want);
          if (rsp.slot_index !== want.slot_index) report("slot_index", rsp, want);
          if (rsp.node_count !== want.node_count) report("node_count", rsp, want);
          if (rsp.rank !== want.rank) report("rank", rsp, want);
          if (rsp.entry_address !== want.entry_address) report("entry_address", rsp, want);
          if (rsp.entry_name !== want.entry_name) report("entry_name", rsp, want);
          if (rsp.entry_hello_count !== want.entry_hello_count)
            report("entry_hello_count", rsp, want);
          if (rsp.entry_valid !== want.entry_valid) report("entry_valid", rsp, want);
          if (rsp.last !== want.last) report("last", rsp, want);
        end
      end
      rsp_stall <= hold_rsp || (!quiet && $urandom_range(99) < 7);
    end
  end

  function automatic in_item_t make_item(logic [1:0] c, logic [15:0] a, logic [63:0] n,
                                        logic [6:0] h);
    in_item_t it;
    it.command = c; it.address = a; it.node_name = n; it.hop_count = h;
    return it;
  endfunction

  function automatic logic [63:0] rand_name();
    logic [63:0] n;
    n = {$urandom, $urandom};
    if ($urandom_range(3) == 0) n[8*$urandom_range(7) +: 8] = 8'd0;
    return n;
  endfunction

  initial begin
    logic [15:0] pool [16];
    logic [1:0] c;
    for (int i = 0; i < SLOTS; i++) begin
      t_addr[i] = '0; t_name[i] = '0; t_min[i] = HOPS_RESET; t_max[i] = '0;
      t_hello[i] = '0; t_beat[i] = '0;
    end
    occupied = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed
    pending_items.push_back(make_item(CMD_REPORT, 16'h0, '1, 7'h7f));
    pending_items.push_back(make_item(CMD_HELLO, 16'h0, 64'h1, 7'h0));
    pending_items.push_back(make_item(CMD_HEARTBEAT, 16'h0, 64'h1, 7'h0));
    pending_items.push_back(make_item(CMD_HEARTBEAT, 16'hffff, '0, 7'd40));
    pending_items.push_back(make_item(CMD_HEARTBEAT, 16'hffff, '0, 7'd10));
    pending_items.push_back(make_item(CMD_HEARTBEAT, 16'hffff, '0, 7'd90));
    pending_items.push_back(make_item(CMD_HEARTBEAT, 16'hffff, '0, 7'd127));
    pending_items.push_back(make_item(CMD_HEARTBEAT, 16'hffff, '0, 7'd0));
    pending_items.push_back(make_item(CMD_HELLO, 16'hffff, '1, 7'h0));
    pending_items.push_back(make_item(CMD_HELLO, 16'h0001, 64'h4142_0043_4445_4647, 7'h0));
    pending_items.push_back(make_item(CMD_HELLO, 16'h0001, 64'h0011_2233_4455_6600, 7'h0));
    pending_items.push_back(make_item(CMD_HELLO, 16'h0002, 64'h5a5a_5a5a_5a5a_5a5a, 7'h0));
    pending_items.push_back(make_item(2'd3, 16'h0002, '1, 7'h7f));
    pending_items.push_back(make_item(CMD_HELLO, 16'h0003, 64'h31, 7'h0));
    pending_items.push_back(make_item(CMD_HELLO, 16'h0004, 64'h32, 7'h0));
    pending_items.push_back(make_item(CMD_HELLO, 16'h0005, 64'h33, 7'h0));
    pending_items.push_back(make_item(CMD_HELLO, 16'h0005, 64'h33, 7'h0));
    pending_items.push_back(make_item(CMD_REPORT, 16'h1234, '0, 7'h0));

    // fill the table past full
    for (int i = 0; i < 130; i++)
      pending_items.push_back(make_item(i[0] ? CMD_HEARTBEAT : CMD_HELLO,
                                        16'h0100 + i[15:0], rand_name(), 7'($urandom)));
    pending_items.push_back(make_item(CMD_REPORT, 16'h0, '0, 7'h0));

    // random traffic over an address pool: eight known addresses, then random ones
    for (int i = 0; i < 16; i++) pool[i] = (i < 8) ? 16'h0100 + i[15:0] : 16'($urandom);
    for (int i = 0; i < 160; i++) begin
      c = 2'($urandom_range(99) < 45 ? CMD_HELLO : $urandom_range(99) < 70 ? CMD_HEARTBEAT :
             $urandom_range(99) < 85 ? CMD_REPORT : 3);
      pending_items.push_back(make_item(c, $urandom_range(9) == 0 ? 16'($urandom) :
                                        pool[$urandom_range(15)], rand_name(), 7'($urandom)));
    end

    wait (pending_items.size() > 140);
    hold_rsp = 1'b1;
    repeat (400) @(posedge clk);
    hold_rsp = 1'b0;
    quiet = 1'b1;
    repeat (3000) @(posedge clk);
    quiet = 1'b0;

    wait (pending_items.size() == 0 && !req_valid);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("node_statistics_table test passed");
    end else begin
      $display("node_statistics_table test failed");
    end
    $finish;
  end

endmodule
